// File: rtl/ll1_parse_stack_engine_defines.svh
// ----------------------------------------------------------------------------
// LL(1) parse stack engine assertion macros
// Shared assertion wrappers for the parse stack engine RTL.
// ----------------------------------------------------------------------------
`ifndef LL1_PARSE_STACK_ENGINE_DEFINES_SVH
`define LL1_PARSE_STACK_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LL1PS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LL1PS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ll1ps_pkg.sv
// ----------------------------------------------------------------------------
// ll1ps_pkg
// Sizes, codes, types and state encoding for the LL(1) parse stack engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ll1ps_pkg;

	// Grammar and storage sizes.
	localparam int NONTERMINALS   = 64;
	localparam int TERMINALS      = 64;
	localparam int PRODUCTIONS    = 256;
	localparam int MAX_RHS        = 8;
	localparam int STACK_DEPTH    = 256;
	localparam int MAX_EXPANSIONS = 32;

	// Field and address widths.
	localparam int CMD_W   = 3;
	localparam int NT_W    = $clog2(NONTERMINALS);
	localparam int T_W     = $clog2(TERMINALS);
	localparam int PROD_W  = $clog2(PRODUCTIONS);
	localparam int POS_W   = $clog2(MAX_RHS);
	localparam int LEN_W   = 4;
	localparam int KIND_W  = 2;
	localparam int ID_W    = 6;
	localparam int SYM_W   = KIND_W + ID_W;
	localparam int STAT_W  = 3;
	localparam int TBL_AW  = NT_W + T_W;
	localparam int TBL_DW  = PROD_W + 1;
	localparam int RHS_AW  = PROD_W + POS_W;
	localparam int STK_AW  = $clog2(STACK_DEPTH);
	localparam int CNT_W   = STK_AW + 1;
	localparam int EXP_W   = 6;

	localparam int TBL_DEPTH = 1 << TBL_AW;
	localparam int RHS_DEPTH = 1 << RHS_AW;
	localparam int LEN_DEPTH = 1 << PROD_W;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TBL_WR = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RHS_WR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LEN_WR = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PARSE  = 3'd5;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOENTRY  = 3'd3;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;
	localparam logic [STAT_W-1:0] ST_LIMIT    = 3'd5;

	// Symbol kinds; anything with the upper bit set is an empty terminal.
	localparam logic [KIND_W-1:0] KIND_TERM    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NONTERM = 2'd1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_POP,
		S_TOP,
		S_TBL,
		S_LEN,
		S_PUSH,
		S_EMIT,
		S_FIN
	} state_t;

	// One input beat.
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [NT_W-1:0]   nonterminal;
		logic [T_W-1:0]    terminal;
		logic [PROD_W-1:0] production;
		logic              entry_valid;
		logic [POS_W-1:0]  rhs_pos;
		logic [LEN_W-1:0]  rhs_len;
		logic [KIND_W-1:0] sym_kind;
		logic [ID_W-1:0]   sym_id;
	} item_t;

	// One result beat handed from the sequencer to the output register.
	typedef struct packed {
		logic              emit;
		logic              has_production;
		logic [PROD_W-1:0] production;
		logic [STAT_W-1:0] status;
		logic              last;
	} res_t;

	// Sequencer status toward the top level.
	typedef struct packed {
		logic             ready;
		logic [CNT_W-1:0] count;
	} seq_stat_t;

	// Memory requests: one write port and one read address each.
	typedef struct packed {
		logic              we;
		logic [TBL_AW-1:0] waddr;
		logic [TBL_DW-1:0] wdata;
		logic [TBL_AW-1:0] raddr;
	} tbl_req_t;

	typedef struct packed {
		logic              we;
		logic [RHS_AW-1:0] waddr;
		logic [SYM_W-1:0]  wdata;
		logic [RHS_AW-1:0] raddr;
	} rhs_req_t;

	typedef struct packed {
		logic              we;
		logic [PROD_W-1:0] waddr;
		logic [LEN_W-1:0]  wdata;
		logic [PROD_W-1:0] raddr;
	} len_req_t;

	typedef struct packed {
		logic              we;
		logic [STK_AW-1:0] waddr;
		logic [SYM_W-1:0]  wdata;
		logic [STK_AW-1:0] raddr;
	} stk_req_t;

endpackage

// File: rtl/ll1ps_ram.sv
// ----------------------------------------------------------------------------
// ll1ps_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ll1ps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/ll1ps_seq.sv
// ----------------------------------------------------------------------------
// ll1ps_seq
// Sequencer for commands, the parse loop and the table clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ll1ps_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  ll1ps_pkg::item_t                   item,
	input  logic                               out_free,
	input  logic [ll1ps_pkg::TBL_DW-1:0]       tbl_rdata,
	input  logic [ll1ps_pkg::SYM_W-1:0]        rhs_rdata,
	input  logic [ll1ps_pkg::LEN_W-1:0]        len_rdata,
	input  logic [ll1ps_pkg::SYM_W-1:0]        stk_rdata,
	output ll1ps_pkg::tbl_req_t                tbl_req,
	output ll1ps_pkg::rhs_req_t                rhs_req,
	output ll1ps_pkg::len_req_t                len_req,
	output ll1ps_pkg::stk_req_t                stk_req,
	output ll1ps_pkg::res_t                    res,
	output ll1ps_pkg::seq_stat_t               stat
);

	ll1ps_pkg::state_t state_q, state_d;

	logic [ll1ps_pkg::TBL_AW-1:0] clr_q, clr_d;
	logic [ll1ps_pkg::CNT_W-1:0]  count_q, count_d;
	logic [ll1ps_pkg::EXP_W-1:0]  exp_q, exp_d;
	logic [ll1ps_pkg::T_W-1:0]    y_q, y_d;
	logic [ll1ps_pkg::PROD_W-1:0] prod_q, prod_d;
	logic [ll1ps_pkg::POS_W-1:0]  rem_q, rem_d;
	logic [ll1ps_pkg::STAT_W-1:0] status_q, status_d;

	logic [ll1ps_pkg::KIND_W-1:0] top_kind;
	logic [ll1ps_pkg::ID_W-1:0]   top_id;
	logic [ll1ps_pkg::CNT_W:0]    need;
	logic [ll1ps_pkg::POS_W-1:0]  rhs_idx;
	logic [ll1ps_pkg::LEN_W-1:0]  len_sat;

	assign top_kind = stk_rdata[ll1ps_pkg::SYM_W-1 -: ll1ps_pkg::KIND_W];
	assign top_id   = stk_rdata[ll1ps_pkg::ID_W-1:0];

	// The stack-room check: current depth plus the right side length.
	assign need = {1'b0, count_q} + (ll1ps_pkg::CNT_W + 1)'(len_rdata);

	assign rhs_idx = (state_q == ll1ps_pkg::S_LEN) ?
		ll1ps_pkg::POS_W'(len_rdata - 1'b1) : rem_q - 1'b1;

	assign len_sat = (item.rhs_len > ll1ps_pkg::LEN_W'(ll1ps_pkg::MAX_RHS)) ?
		ll1ps_pkg::LEN_W'(ll1ps_pkg::MAX_RHS) : item.rhs_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ll1ps_pkg::S_CLEAR;
			clr_q    <= '0;
			count_q  <= '0;
			exp_q    <= '0;
			status_q <= ll1ps_pkg::ST_OK;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			count_q  <= count_d;
			exp_q    <= exp_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		y_q    <= y_d;
		prod_q <= prod_d;
		rem_q  <= rem_d;
	end

	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		count_d  = count_q;
		exp_d    = exp_q;
		y_d      = y_q;
		prod_d   = prod_q;
		rem_d    = rem_q;
		status_d = status_q;

		// Read addresses follow the datapath all the time; the state decides
		// when the registered data is used.
		tbl_req.we    = 1'b0;
		tbl_req.waddr = clr_q;
		tbl_req.wdata = '0;
		tbl_req.raddr = {top_id[ll1ps_pkg::NT_W-1:0], y_q};

		rhs_req.we    = 1'b0;
		rhs_req.waddr = {item.production, item.rhs_pos};
		rhs_req.wdata = {item.sym_kind, item.sym_id};
		rhs_req.raddr = {prod_q, rhs_idx};

		len_req.we    = 1'b0;
		len_req.waddr = clr_q[ll1ps_pkg::PROD_W-1:0];
		len_req.wdata = '0;
		len_req.raddr = tbl_rdata[ll1ps_pkg::PROD_W-1:0];

		stk_req.we    = 1'b0;
		stk_req.waddr = count_q[ll1ps_pkg::STK_AW-1:0];
		stk_req.wdata = {item.sym_kind, item.sym_id};
		stk_req.raddr = ll1ps_pkg::STK_AW'(count_q - 1'b1);

		res.emit           = 1'b0;
		res.has_production = 1'b0;
		res.production     = '0;
		res.status         = status_q;
		res.last           = 1'b1;

		case (state_q)
			ll1ps_pkg::S_CLEAR: begin
				tbl_req.we = 1'b1;
				len_req.we = 1'b1;
				clr_d = clr_q + 1'b1;
				if (&clr_q) begin
					state_d = ll1ps_pkg::S_IDLE;
				end
			end
			ll1ps_pkg::S_IDLE: begin
				if (in_valid) begin
					status_d = ll1ps_pkg::ST_OK;
					state_d  = ll1ps_pkg::S_FIN;
					case (item.cmd)
						ll1ps_pkg::CMD_TBL_WR: begin
							tbl_req.we    = 1'b1;
							tbl_req.waddr = {item.nonterminal, item.terminal};
							tbl_req.wdata = item.entry_valid ?
								{1'b1, item.production} : '0;
						end
						ll1ps_pkg::CMD_RHS_WR: begin
							rhs_req.we = 1'b1;
						end
						ll1ps_pkg::CMD_LEN_WR: begin
							len_req.we    = 1'b1;
							len_req.waddr = item.production;
							len_req.wdata = len_sat;
						end
						ll1ps_pkg::CMD_CLEAR: begin
							count_d = '0;
						end
						ll1ps_pkg::CMD_PUSH: begin
							if (count_q >= ll1ps_pkg::CNT_W'(ll1ps_pkg::STACK_DEPTH)) begin
								status_d = ll1ps_pkg::ST_OVERFLOW;
							end else begin
								stk_req.we = 1'b1;
								count_d    = count_q + 1'b1;
							end
						end
						ll1ps_pkg::CMD_PARSE: begin
							y_d     = item.terminal;
							exp_d   = '0;
							state_d = ll1ps_pkg::S_POP;
						end
						default: begin
						end
					endcase
				end
			end
			ll1ps_pkg::S_POP: begin
				if (count_q == '0) begin
					status_d = ll1ps_pkg::ST_EMPTY;
					state_d  = ll1ps_pkg::S_FIN;
				end else begin
					state_d = ll1ps_pkg::S_TOP;
				end
			end
			ll1ps_pkg::S_TOP: begin
				if (top_kind == ll1ps_pkg::KIND_NONTERM &&
				    exp_q >= ll1ps_pkg::EXP_W'(ll1ps_pkg::MAX_EXPANSIONS)) begin
					status_d = ll1ps_pkg::ST_LIMIT;
					state_d  = ll1ps_pkg::S_FIN;
				end else begin
					count_d = count_q - 1'b1;
					if (top_kind[ll1ps_pkg::KIND_W-1]) begin
						state_d = ll1ps_pkg::S_POP;
					end else if (top_kind == ll1ps_pkg::KIND_TERM) begin
						status_d = (top_id == y_q) ? ll1ps_pkg::ST_OK :
							ll1ps_pkg::ST_MISMATCH;
						state_d  = ll1ps_pkg::S_FIN;
					end else begin
						state_d = ll1ps_pkg::S_TBL;
					end
				end
			end
			ll1ps_pkg::S_TBL: begin
				if (!tbl_rdata[ll1ps_pkg::TBL_DW-1]) begin
					status_d = ll1ps_pkg::ST_NOENTRY;
					state_d  = ll1ps_pkg::S_FIN;
				end else begin
					prod_d  = tbl_rdata[ll1ps_pkg::PROD_W-1:0];
					state_d = ll1ps_pkg::S_LEN;
				end
			end
			ll1ps_pkg::S_LEN: begin
				if (need > (ll1ps_pkg::CNT_W + 1)'(ll1ps_pkg::STACK_DEPTH)) begin
					status_d = ll1ps_pkg::ST_OVERFLOW;
					state_d  = ll1ps_pkg::S_FIN;
				end else if (len_rdata == '0) begin
					state_d = ll1ps_pkg::S_EMIT;
				end else begin
					rem_d   = rhs_idx;
					state_d = ll1ps_pkg::S_PUSH;
				end
			end
			ll1ps_pkg::S_PUSH: begin
				// Write the symbol read last cycle and fetch the one below it.
				stk_req.we    = 1'b1;
				stk_req.wdata = rhs_rdata;
				count_d       = count_q + 1'b1;
				if (rem_q == '0) begin
					state_d = ll1ps_pkg::S_EMIT;
				end else begin
					rem_d = rhs_idx;
				end
			end
			ll1ps_pkg::S_EMIT: begin
				if (out_free) begin
					res.emit           = 1'b1;
					res.has_production = 1'b1;
					res.production     = prod_q;
					res.status         = ll1ps_pkg::ST_OK;
					res.last           = 1'b0;
					exp_d              = exp_q + 1'b1;
					state_d            = ll1ps_pkg::S_POP;
				end
			end
			ll1ps_pkg::S_FIN: begin
				if (out_free) begin
					res.emit = 1'b1;
					state_d  = ll1ps_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ll1ps_pkg::S_IDLE;
			end
		endcase
	end

	assign stat.ready = (state_q == ll1ps_pkg::S_IDLE);
	assign stat.count = count_q;

endmodule

// File: rtl/ll1_parse_stack_engine.sv
// ----------------------------------------------------------------------------
// ll1_parse_stack_engine
// LL(1) predictive parser: parse table, production store and symbol stack.
// ----------------------------------------------------------------------------
// After reset the engine clears the parse table and the right-side length
// store, one table entry a cycle, and holds in_stall high until that pass
// is done. From then on it takes one input beat at a time. A load, clear or
// push command accepts the beat and updates the memory or stack, then its
// single result beat is loaded into the output register from the final
// state once that register is free. A parse command accepts the beat, pops
// and examines each symbol in turn, and for every expansion looks up the
// table entry and the right-side length, pushes each right-side symbol and
// emits a result beat; it ends when a terminal is compared, an error is found
// or the stack is found empty, and then loads the final result. A stalled
// output pauses it wherever a result beat waits. The sequencer walks one
// stack pop, one table lookup, one length lookup and one stack push at a
// time through memories with one write port and one registered read port.
// Each expansion yields a result beat with has_production set, and the
// parse ends with one beat carrying last and the status. Result beats sit
// in an output register, so a stalled output only pauses the sequencer, and
// the next input beat is accepted as soon as the final result of the
// previous one has been loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ll1_parse_stack_engine_defines.svh"

module ll1_parse_stack_engine (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ll1ps_pkg::CMD_W-1:0]        cmd,
	input  logic [ll1ps_pkg::NT_W-1:0]         nonterminal,
	input  logic [ll1ps_pkg::T_W-1:0]          terminal,
	input  logic [ll1ps_pkg::PROD_W-1:0]       production,
	input  logic                               entry_valid,
	input  logic [ll1ps_pkg::POS_W-1:0]        rhs_pos,
	input  logic [ll1ps_pkg::LEN_W-1:0]        rhs_len,
	input  logic [ll1ps_pkg::KIND_W-1:0]       sym_kind,
	input  logic [ll1ps_pkg::ID_W-1:0]         sym_id,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               has_production,
	output logic [ll1ps_pkg::PROD_W-1:0]       production_out,
	output logic [ll1ps_pkg::STAT_W-1:0]       status,
	output logic                               last
);

	ll1ps_pkg::item_t     item;
	ll1ps_pkg::res_t      res;
	ll1ps_pkg::seq_stat_t stat;
	ll1ps_pkg::tbl_req_t  tbl_req;
	ll1ps_pkg::rhs_req_t  rhs_req;
	ll1ps_pkg::len_req_t  len_req;
	ll1ps_pkg::stk_req_t  stk_req;

	logic [ll1ps_pkg::TBL_DW-1:0] tbl_rdata;
	logic [ll1ps_pkg::SYM_W-1:0]  rhs_rdata;
	logic [ll1ps_pkg::LEN_W-1:0]  len_rdata;
	logic [ll1ps_pkg::SYM_W-1:0]  stk_rdata;

	logic                          out_valid_q;
	logic                          has_prod_q;
	logic [ll1ps_pkg::PROD_W-1:0]  prod_out_q;
	logic [ll1ps_pkg::STAT_W-1:0]  status_q;
	logic                          last_q;
	logic                          out_free;

	assign item.cmd         = cmd;
	assign item.nonterminal = nonterminal;
	assign item.terminal    = terminal;
	assign item.production  = production;
	assign item.entry_valid = entry_valid;
	assign item.rhs_pos     = rhs_pos;
	assign item.rhs_len     = rhs_len;
	assign item.sym_kind    = sym_kind;
	assign item.sym_id      = sym_id;

	// The engine only takes a beat when the sequencer is idle.
	assign in_stall = ~stat.ready;

	// The output register can take a new result when it is empty or its
	// current beat is being taken this cycle.
	assign out_free = ~out_valid_q | ~out_stall;

	ll1ps_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.item      (item),
		.out_free  (out_free),
		.tbl_rdata (tbl_rdata),
		.rhs_rdata (rhs_rdata),
		.len_rdata (len_rdata),
		.stk_rdata (stk_rdata),
		.tbl_req   (tbl_req),
		.rhs_req   (rhs_req),
		.len_req   (len_req),
		.stk_req   (stk_req),
		.res       (res),
		.stat      (stat)
	);

	// Parse table: valid bit over a production id, indexed by
	// nonterminal and terminal.
	ll1ps_ram #(
		.WIDTH (ll1ps_pkg::TBL_DW),
		.DEPTH (ll1ps_pkg::TBL_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_req.we),
		.waddr (tbl_req.waddr),
		.wdata (tbl_req.wdata),
		.raddr (tbl_req.raddr),
		.rdata (tbl_rdata)
	);

	// Right-side symbols, indexed by production and position.
	ll1ps_ram #(
		.WIDTH (ll1ps_pkg::SYM_W),
		.DEPTH (ll1ps_pkg::RHS_DEPTH)
	) u_rhs_ram (
		.clk   (clk),
		.we    (rhs_req.we),
		.waddr (rhs_req.waddr),
		.wdata (rhs_req.wdata),
		.raddr (rhs_req.raddr),
		.rdata (rhs_rdata)
	);

	// Right-side lengths, one per production.
	ll1ps_ram #(
		.WIDTH (ll1ps_pkg::LEN_W),
		.DEPTH (ll1ps_pkg::LEN_DEPTH)
	) u_len_ram (
		.clk   (clk),
		.we    (len_req.we),
		.waddr (len_req.waddr),
		.wdata (len_req.wdata),
		.raddr (len_req.raddr),
		.rdata (len_rdata)
	);

	// Symbol stack.
	ll1ps_ram #(
		.WIDTH (ll1ps_pkg::SYM_W),
		.DEPTH (ll1ps_pkg::STACK_DEPTH)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_req.we),
		.waddr (stk_req.waddr),
		.wdata (stk_req.wdata),
		.raddr (stk_req.raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.emit) begin
			has_prod_q <= res.has_production;
			prod_out_q <= res.production;
			status_q   <= res.status;
			last_q     <= res.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign has_production = has_prod_q;
	assign production_out = prod_out_q;
	assign status         = status_q;
	assign last           = last_q;

	// An accepted beat keeps the engine busy for at least the next cycle.
	`LL1PS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall,
		in_stall, "engine accepted a beat and was ready again at once")

	// A held result must never be overwritten by the sequencer.
	`LL1PS_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid_q && out_stall,
		!res.emit, "result emitted while the output register was stalled")

	// The stack depth never runs past the stack memory.
	`LL1PS_ASSERT_NOW(a_stack_bound, clk, arst_n, 1'b1,
		stat.count <= ll1ps_pkg::CNT_W'(ll1ps_pkg::STACK_DEPTH),
		"symbol stack count beyond its depth")

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// LL(1) parse stack engine testbench
// Drives load, stack and parse beats into the engine with random gaps on both
// channels and checks every result beat against a behavioral mirror of the
// parse table, production store and symbol stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import ll1ps_pkg::*;

	localparam int CYCLE_LIMIT     = 1_500_000;
	localparam int RANDOM_BEATS    = 360;
	localparam int SETTLE_CYCLES   = 64;
	localparam int GAP_MAX         = 10;
	localparam int LONG_HOLD       = 300;
	localparam int LONG_HOLD_AFTER = 150;

	// Both kinds with the upper bit set are skipped as empty terminals.
	localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_EMPTY_ALT = 2'd3;

	// Command codes the engine does not decode.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic              has_production;
		logic [PROD_W-1:0] production;
		logic [STAT_W-1:0] status;
		logic              last;
	} result_t;

	// Mirror of the engine state; predicts the result beats of each accepted
	// input beat and checks the beats that come back.
	class ll1_mirror;
		logic [TBL_DW-1:0] parse_map [TBL_DEPTH];
		logic [SYM_W-1:0]  rhs_store [RHS_DEPTH];
		logic [LEN_W-1:0]  rhs_size  [LEN_DEPTH];
		logic [SYM_W-1:0]  sym_stack [STACK_DEPTH];
		int                depth;
		int                errors;
		result_t           pending_results [$];

		function new();
			foreach (parse_map[i]) parse_map[i] = '0;
			foreach (rhs_store[i]) rhs_store[i] = '0;
			foreach (rhs_size[i]) rhs_size[i] = '0;
			foreach (sym_stack[i]) sym_stack[i] = '0;
			depth  = 0;
			errors = 0;
		endfunction

		function void add_result(logic hp, logic [PROD_W-1:0] p, logic [STAT_W-1:0] st,
				logic l);
			pending_results.insert(pending_results.size(), result_t'{hp, p, st, l});
		endfunction

		function void add_final(logic [STAT_W-1:0] st);
			add_result(1'b0, '0, st, 1'b1);
		endfunction

		// Pops and expands until a terminal is compared or an error stops it.
		function void expand_lookahead(logic [T_W-1:0] look);
			int                expansions;
			int                len;
			bit                done;
			logic [SYM_W-1:0]  top;
			logic [KIND_W-1:0] kind;
			logic [TBL_DW-1:0] entry;
			logic [PROD_W-1:0] prod;
			expansions = 0;
			done       = 0;
			while (!done) begin
				if (depth == 0) begin
					add_final(ST_EMPTY);
					done = 1;
				end else begin
					top  = sym_stack[STK_AW'(depth - 1)];
					kind = top[SYM_W-1 -: KIND_W];
					if (kind == KIND_NONTERM && expansions >= MAX_EXPANSIONS) begin
						// The nonterminal stays on the stack for the next lookahead.
						add_final(ST_LIMIT);
						done = 1;
					end else begin
						depth--;
						if (kind == KIND_TERM) begin
							add_final((top[ID_W-1:0] == look) ? ST_OK : ST_MISMATCH);
							done = 1;
						end else if (kind == KIND_NONTERM) begin
							if (int'(top[ID_W-1:0]) >= NONTERMINALS ||
									int'(look) >= TERMINALS) begin
								add_final(ST_NOENTRY);
								done = 1;
							end else begin
								entry = parse_map[{top[ID_W-1:0], look}];
								prod  = entry[PROD_W-1:0];
								len   = int'(rhs_size[prod]);
								if (!entry[PROD_W]) begin
									add_final(ST_NOENTRY);
									done = 1;
								end else if (depth + len > STACK_DEPTH) begin
									add_final(ST_OVERFLOW);
									done = 1;
								end else begin
									// Right side goes on in reverse, position zero on top.
									for (int i = len; i > 0; i--) begin
										sym_stack[STK_AW'(depth)] =
											rhs_store[{prod, POS_W'(i - 1)}];
										depth++;
									end
									expansions++;
									add_result(1'b1, prod, ST_OK, 1'b0);
								end
							end
						end
					end
				end
			end
		endfunction

		function void accept_beat(item_t b);
			logic [STAT_W-1:0] st;
			logic [SYM_W-1:0]  sym;
			st  = ST_OK;
			sym = {b.sym_kind, b.sym_id};
			case (b.cmd)
				CMD_TBL_WR: begin
					if (int'(b.nonterminal) < NONTERMINALS && int'(b.terminal) < TERMINALS &&
							int'(b.production) < PRODUCTIONS)
						parse_map[{b.nonterminal, b.terminal}] =
							b.entry_valid ? {1'b1, b.production} : '0;
				end
				CMD_RHS_WR: begin
					if (int'(b.production) < PRODUCTIONS && int'(b.rhs_pos) < MAX_RHS)
						rhs_store[{b.production, b.rhs_pos}] = sym;
				end
				CMD_LEN_WR: begin
					if (int'(b.production) < PRODUCTIONS)
						rhs_size[b.production] =
							(b.rhs_len > MAX_RHS) ? LEN_W'(MAX_RHS) : b.rhs_len;
				end
				CMD_CLEAR: depth = 0;
				CMD_PUSH: begin
					if (depth >= STACK_DEPTH) begin
						st = ST_OVERFLOW;
					end else begin
						sym_stack[STK_AW'(depth)] = sym;
						depth++;
					end
				end
				default: ;
			endcase
			if (b.cmd == CMD_PARSE)
				expand_lookahead(b.terminal);
			else
				add_final(st);
		endfunction

		function void compare_field(string name, logic [PROD_W-1:0] want_v,
				logic [PROD_W-1:0] got_v);
			if (want_v !== got_v) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
					want_v, got_v);
				errors++;
			end
		endfunction

		function void check_beat(logic hp, logic [PROD_W-1:0] p, logic [STAT_W-1:0] st,
				logic l);
			result_t want;
			if (pending_results.size() == 0) begin
				$display({"%0t: unexpected result beat: has_production %0d ",
					"production %0d status %0d last %0d"}, $time, hp, p, st, l);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("has_production", want.has_production, hp);
			compare_field("production_out", want.production, p);
			compare_field("status", want.status, st);
			compare_field("last", want.last, l);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	item_t             drv;
	logic              out_valid;
	logic              out_stall;
	logic              has_production;
	logic [PROD_W-1:0] production_out;
	logic [STAT_W-1:0] status;
	logic              last;

	ll1_mirror mirror = new();

	// Which right-side positions have been written, so that no expansion ever
	// reads a symbol slot that was never loaded.
	logic [MAX_RHS-1:0] rhs_filled [PRODUCTIONS];
	int                 gap_limit;
	int                 beats_sent;
	int                 cycle_count = 0;

	ll1_parse_stack_engine DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (drv.cmd),
		.nonterminal   (drv.nonterminal),
		.terminal      (drv.terminal),
		.production    (drv.production),
		.entry_valid   (drv.entry_valid),
		.rhs_pos       (drv.rhs_pos),
		.rhs_len       (drv.rhs_len),
		.sym_kind      (drv.sym_kind),
		.sym_id        (drv.sym_id),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.has_production(has_production),
		.production_out(production_out),
		.status        (status),
		.last          (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both handshakes are sampled at the rising edge; the input beat is noted
	// before the output is checked, though a beat never answers in its own cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				mirror.accept_beat(drv);
			if (out_valid && !out_stall)
				mirror.check_beat(has_production, production_out, status, last);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: after every accepted beat, stall for a random count of
	// cycles. Once, well into the run, hold off long enough that the output
	// register and sequencer back up and the engine stalls its input.
	initial begin
		int hold;
		int taken;
		out_stall = 1'b0;
		taken     = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
			taken++;
			hold = (taken == LONG_HOLD_AFTER) ? LONG_HOLD : $urandom_range(0, gap_limit);
			if (hold > 0) begin
				repeat (hold) begin
					@(negedge clk);
					out_stall = 1'b1;
				end
				@(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Fields a command does not use still carry random bits.
	function automatic item_t random_beat(logic [CMD_W-1:0] c);
		logic [63:0] r;
		item_t       b;
		r     = {$urandom, $urandom};
		b     = r[$bits(item_t)-1:0];
		b.cmd = c;
		return b;
	endfunction

	// Presents one beat at the falling edge after a random gap and holds it
	// until the engine takes it. With no gap, valid simply stays high.
	task automatic drive_beat(item_t b);
		int gap;
		gap = $urandom_range(0, gap_limit);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		drv      = b;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// A length write first loads any symbol slot under the new length that
	// has never been written.
	task automatic send_beat(item_t b);
		item_t fill;
		int    n;
		if (b.cmd == CMD_LEN_WR) begin
			n = (b.rhs_len > MAX_RHS) ? MAX_RHS : int'(b.rhs_len);
			for (int pos = 0; pos < n; pos++) begin
				if (!rhs_filled[b.production][POS_W'(pos)]) begin
					fill            = random_beat(CMD_RHS_WR);
					fill.production = b.production;
					fill.rhs_pos    = POS_W'(pos);
					drive_beat(fill);
					rhs_filled[b.production][POS_W'(pos)] = 1'b1;
					beats_sent++;
				end
			end
		end
		if (b.cmd == CMD_RHS_WR)
			rhs_filled[b.production][b.rhs_pos] = 1'b1;
		drive_beat(b);
		if (b.cmd <= CMD_PARSE)
			beats_sent++;
	endtask

	task automatic write_rhs(logic [PROD_W-1:0] p, int pos, logic [KIND_W-1:0] kind,
			logic [ID_W-1:0] id);
		item_t b;
		b            = random_beat(CMD_RHS_WR);
		b.production = p;
		b.rhs_pos    = POS_W'(pos);
		b.sym_kind   = kind;
		b.sym_id     = id;
		send_beat(b);
	endtask

	task automatic write_len(logic [PROD_W-1:0] p, int len);
		item_t b;
		b            = random_beat(CMD_LEN_WR);
		b.production = p;
		b.rhs_len    = LEN_W'(len);
		send_beat(b);
	endtask

	task automatic write_entry(logic [NT_W-1:0] nt, logic [T_W-1:0] t, logic v,
			logic [PROD_W-1:0] p);
		item_t b;
		b             = random_beat(CMD_TBL_WR);
		b.nonterminal = nt;
		b.terminal    = t;
		b.entry_valid = v;
		b.production  = p;
		send_beat(b);
	endtask

	task automatic push_sym(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id);
		item_t b;
		b          = random_beat(CMD_PUSH);
		b.sym_kind = kind;
		b.sym_id   = id;
		send_beat(b);
	endtask

	task automatic parse_tok(logic [T_W-1:0] t);
		item_t b;
		b          = random_beat(CMD_PARSE);
		b.terminal = t;
		send_beat(b);
	endtask

	task automatic clear_stack();
		send_beat(random_beat(CMD_CLEAR));
	endtask

	// A small random grammar over four adjacent terminals, three nonterminals
	// and four productions, then a start symbol and a few lookaheads. Mostly
	// short right sides; now and then a long one or a saturating length.
	task automatic grammar_round();
		logic [T_W-1:0]    tok_base;
		logic [NT_W-1:0]   nts [3];
		logic [PROD_W-1:0] prods [4];
		int                lenv;
		int                n;
		int                r;
		tok_base = T_W'($urandom);
		foreach (nts[i]) nts[i] = NT_W'($urandom);
		foreach (prods[j]) prods[j] = PROD_W'($urandom);
		foreach (prods[j]) begin
			lenv = ($urandom_range(0, 7) == 0) ?
				$urandom_range(MAX_RHS / 2, (1 << LEN_W) - 1) : $urandom_range(0, 3);
			n = (lenv > MAX_RHS) ? MAX_RHS : lenv;
			for (int pos = 0; pos < n; pos++) begin
				r = $urandom_range(0, 9);
				if (r < 5)
					write_rhs(prods[j], pos, KIND_TERM,
						ID_W'(tok_base + $urandom_range(0, 3)));
				else if (r < 8)
					write_rhs(prods[j], pos, KIND_NONTERM, nts[$urandom_range(0, 2)]);
				else
					write_rhs(prods[j], pos,
						$urandom_range(0, 1) ? KIND_EMPTY : KIND_EMPTY_ALT, ID_W'($urandom));
			end
			write_len(prods[j], lenv);
		end
		foreach (nts[i]) begin
			for (int k = 0; k < 4; k++) begin
				if ($urandom_range(0, 3) != 0)
					write_entry(nts[i], T_W'(tok_base + k), $urandom_range(0, 7) != 0,
						prods[$urandom_range(0, 3)]);
			end
		end
		if ($urandom_range(0, 1))
			clear_stack();
		push_sym(KIND_TERM, ID_W'(tok_base + $urandom_range(0, 3)));
		push_sym(KIND_NONTERM, nts[0]);
		repeat ($urandom_range(3, 6))
			parse_tok(T_W'(($urandom_range(0, 7) == 0) ?
				$urandom : tok_base + $urandom_range(0, 3)));
	endtask

	initial begin
		int start_count;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		drv        = '0;
		gap_limit  = GAP_MAX;
		beats_sent = 0;
		foreach (rhs_filled[i]) rhs_filled[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty terminal of the second kind is skipped, leaving an empty stack.
		push_sym(KIND_EMPTY_ALT, '1);
		parse_tok('0);

		// Self-recursive top production with a saturated length: the first parse
		// runs into the expansion limit, the second overflows the stack.
		write_rhs(PROD_W'(PRODUCTIONS - 1), 0, KIND_NONTERM, ID_W'(NONTERMINALS - 1));
		for (int pos = 1; pos < MAX_RHS; pos++)
			write_rhs(PROD_W'(PRODUCTIONS - 1), pos, KIND_TERM, ID_W'(pos));
		write_len(PROD_W'(PRODUCTIONS - 1), (1 << LEN_W) - 1);
		write_entry(NT_W'(NONTERMINALS - 1), T_W'(TERMINALS - 1), 1'b1,
			PROD_W'(PRODUCTIONS - 1));
		push_sym(KIND_NONTERM, ID_W'(NONTERMINALS - 1));
		parse_tok(T_W'(TERMINALS - 1));
		parse_tok(T_W'(TERMINALS - 1));

		// Fill the stack to the top; the last push finds it full.
		repeat (5) push_sym(KIND_TERM, ID_W'(TERMINALS - 1));

		// Removed entry gives a missing table entry.
		clear_stack();
		write_entry(NT_W'(NONTERMINALS - 1), T_W'(TERMINALS - 1), 1'b0,
			PROD_W'(PRODUCTIONS - 1));
		push_sym(KIND_NONTERM, ID_W'(NONTERMINALS - 1));
		parse_tok(T_W'(TERMINALS - 1));
		send_beat(random_beat(CMD_SPARE_LO));
		send_beat(random_beat(CMD_SPARE_HI));

		// Random part: mostly grammar rounds, some noise beats of any command,
		// and every fourth round or so without gaps on either side.
		start_count = beats_sent;
		while (beats_sent - start_count < RANDOM_BEATS) begin
			gap_limit = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
			if ($urandom_range(0, 9) < 7) begin
				grammar_round();
			end else begin
				repeat ($urandom_range(4, 10))
					send_beat(random_beat(CMD_W'($urandom)));
			end
		end
		gap_limit = GAP_MAX;
		@(negedge clk);
		in_valid = 1'b0;

		while (mirror.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mirror.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ll1ps_pkg.sv
rtl/ll1ps_ram.sv
rtl/ll1ps_seq.sv
rtl/ll1_parse_stack_engine.sv
tb/sv/testbench.sv
